// File: src/ilp_pkg.sv
// Package with types, constants and opcode tables of the instruction length predecoder.
package ilp_pkg;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic CSR_REG_START_STATUS = 1'b0;

   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [7:0] START_STATUS_RESET = 8'h30;
   localparam int unsigned FLAG_X_BIT = 4;
   localparam int unsigned FLAG_M_BIT = 5;
   localparam logic [7:0] OPC_SEP = 8'he2;
   localparam logic [7:0] OPC_REP = 8'hc2;

   typedef enum logic [4:0] {
      AM_I8  = 5'd0,
      AM_IM  = 5'd1,
      AM_IX  = 5'd2,
      AM_AC  = 5'd3,
      AM_BR  = 5'd4,
      AM_BL  = 5'd5,
      AM_NO  = 5'd6,
      AM_Z   = 5'd7,
      AM_ZX  = 5'd8,
      AM_ZY  = 5'd9,
      AM_ZI  = 5'd10,
      AM_ZIX = 5'd11,
      AM_ZIY = 5'd12,
      AM_ZL  = 5'd13,
      AM_ZLY = 5'd14,
      AM_A   = 5'd15,
      AM_AX  = 5'd16,
      AM_AY  = 5'd17,
      AM_L   = 5'd18,
      AM_LX  = 5'd19,
      AM_S   = 5'd20,
      AM_SIY = 5'd21,
      AM_AI  = 5'd22,
      AM_AIX = 5'd23,
      AM_MV  = 5'd24
   } addr_mode_type;

   localparam addr_mode_type MODE_TABLE [256] = '{
      AM_I8, AM_ZIX, AM_I8, AM_S, AM_Z, AM_Z, AM_Z, AM_ZL,
      AM_NO, AM_IM, AM_AC, AM_NO, AM_A, AM_A, AM_A, AM_L,
      AM_BR, AM_ZIY, AM_ZI, AM_SIY, AM_Z, AM_ZX, AM_ZX, AM_ZLY,
      AM_NO, AM_AY, AM_AC, AM_NO, AM_A, AM_AX, AM_AX, AM_LX,
      AM_A, AM_ZIX, AM_L, AM_S, AM_Z, AM_Z, AM_Z, AM_ZL,
      AM_NO, AM_IM, AM_AC, AM_NO, AM_A, AM_A, AM_A, AM_L,
      AM_BR, AM_ZIY, AM_ZI, AM_SIY, AM_ZX, AM_ZX, AM_ZX, AM_ZLY,
      AM_NO, AM_AY, AM_AC, AM_NO, AM_AX, AM_AX, AM_AX, AM_LX,
      AM_NO, AM_ZIX, AM_I8, AM_S, AM_MV, AM_Z, AM_Z, AM_ZL,
      AM_NO, AM_IM, AM_AC, AM_NO, AM_A, AM_A, AM_A, AM_L,
      AM_BR, AM_ZIY, AM_ZI, AM_SIY, AM_MV, AM_ZX, AM_ZX, AM_ZLY,
      AM_NO, AM_AY, AM_NO, AM_NO, AM_L, AM_AX, AM_AX, AM_LX,
      AM_NO, AM_ZIX, AM_BL, AM_S, AM_Z, AM_Z, AM_Z, AM_ZL,
      AM_NO, AM_IM, AM_AC, AM_NO, AM_AI, AM_A, AM_A, AM_L,
      AM_BR, AM_ZIY, AM_ZI, AM_SIY, AM_ZX, AM_ZX, AM_ZX, AM_ZLY,
      AM_NO, AM_AY, AM_NO, AM_NO, AM_AIX, AM_AX, AM_AX, AM_LX,
      AM_BR, AM_ZIX, AM_BL, AM_S, AM_Z, AM_Z, AM_Z, AM_ZL,
      AM_NO, AM_IM, AM_NO, AM_NO, AM_A, AM_A, AM_A, AM_L,
      AM_BR, AM_ZIY, AM_ZI, AM_SIY, AM_ZX, AM_ZX, AM_ZY, AM_ZLY,
      AM_NO, AM_AY, AM_NO, AM_NO, AM_A, AM_AX, AM_AX, AM_LX,
      AM_IX, AM_ZIX, AM_IX, AM_S, AM_Z, AM_Z, AM_Z, AM_ZL,
      AM_NO, AM_IM, AM_NO, AM_NO, AM_A, AM_A, AM_A, AM_L,
      AM_BR, AM_ZIY, AM_ZI, AM_SIY, AM_ZX, AM_ZX, AM_ZY, AM_ZLY,
      AM_NO, AM_AY, AM_NO, AM_NO, AM_AX, AM_AX, AM_AY, AM_LX,
      AM_IX, AM_ZIX, AM_I8, AM_S, AM_Z, AM_Z, AM_Z, AM_ZL,
      AM_NO, AM_IM, AM_NO, AM_NO, AM_A, AM_A, AM_A, AM_L,
      AM_BR, AM_ZIY, AM_ZI, AM_SIY, AM_ZI, AM_ZX, AM_ZX, AM_ZLY,
      AM_NO, AM_AY, AM_NO, AM_NO, AM_AI, AM_AX, AM_AX, AM_LX,
      AM_IX, AM_ZIX, AM_I8, AM_S, AM_Z, AM_Z, AM_Z, AM_ZL,
      AM_NO, AM_IM, AM_NO, AM_NO, AM_A, AM_A, AM_A, AM_L,
      AM_BR, AM_ZIY, AM_ZI, AM_SIY, AM_A, AM_ZX, AM_ZX, AM_ZLY,
      AM_NO, AM_AY, AM_NO, AM_NO, AM_AIX, AM_AX, AM_AX, AM_LX
   };

   typedef struct packed {
      logic [23:0]   instr_address;
      addr_mode_type mode;
      logic [2:0]    length;
      logic [7:0]    first_byte;
      logic [7:0]    second_byte;
      logic [7:0]    third_byte;
      logic [7:0]    status_after;
   } decoded_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   function automatic logic [2:0] instr_length(addr_mode_type mode, logic [7:0] status);
      logic [2:0] len;
      unique case (mode)
         AM_AC, AM_NO: len = 3'd1;
         AM_IM: len = status[FLAG_M_BIT] ? 3'd2 : 3'd3;
         AM_IX: len = status[FLAG_X_BIT] ? 3'd2 : 3'd3;
         AM_I8, AM_BR, AM_Z, AM_ZX, AM_ZY, AM_ZI, AM_ZIX, AM_ZIY, AM_ZL, AM_ZLY,
         AM_S, AM_SIY: len = 3'd2;
         AM_BL, AM_A, AM_AX, AM_AY, AM_AI, AM_AIX, AM_MV: len = 3'd3;
         AM_L, AM_LX: len = 3'd4;
         default: len = 3'd1;
      endcase
      return len;
   endfunction

endpackage

// File: src/ilp_req_if.sv
// Request channel interface of the instruction length predecoder.
interface ilp_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] instr_address;
   logic [7:0]  opcode_byte;
   logic [7:0]  first_byte;
   logic [7:0]  second_byte;
   logic [7:0]  third_byte;

   modport source (
      output valid, instr_address, opcode_byte, first_byte, second_byte, third_byte,
      input  ready
   );
   modport sink (
      input  valid, instr_address, opcode_byte, first_byte, second_byte, third_byte,
      output ready
   );
endinterface

// File: src/ilp_rsp_if.sv
// Response channel interface of the instruction length predecoder.
interface ilp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  length;
   logic [4:0]  addr_mode;
   logic [23:0] operand_value;
   logic [23:0] branch_target;
   logic [7:0]  status_after;

   modport source (
      output valid, length, addr_mode, operand_value, branch_target, status_after,
      input  ready
   );
   modport sink (
      input  valid, length, addr_mode, operand_value, branch_target, status_after,
      output ready
   );
endinterface

// File: src/ilp_front.sv
// Front end: accepts requests, classifies the opcode and tracks the status byte.
module ilp_front (
   input  logic                                clock,
   input  logic                                reset,
   ilp_req_if.sink                             req_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ilp_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [ilp_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ilp_pkg::CSR_DATA_W-1:0]      csr_prdata,
   input  ilp_pkg::queue_status_type           queue_status,
   output logic                                push,
   output ilp_pkg::decoded_type                push_entry
);

   logic [7:0]             start_status_ff;
   logic [7:0]             start_status_in;
   logic [7:0]             status_ff;
   logic [7:0]             status_in;
   logic                   csr_write;
   logic                   csr_hit;
   ilp_pkg::addr_mode_type mode;

   assign csr_hit   = csr_paddr[ilp_pkg::CSR_ADDR_W-1] == ilp_pkg::CSR_REG_START_STATUS;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_hit;
   assign csr_prdata = csr_hit ? {{(ilp_pkg::CSR_DATA_W-8){1'b0}}, start_status_ff}
                               : '0;

   assign req_chan.ready = !queue_status.full;
   assign push = req_chan.valid && !queue_status.full;

   assign mode = ilp_pkg::MODE_TABLE[req_chan.opcode_byte];

   always_comb begin
      status_in = status_ff;
      if (req_chan.opcode_byte == ilp_pkg::OPC_SEP) begin
         status_in = status_ff | req_chan.first_byte;
      end else if (req_chan.opcode_byte == ilp_pkg::OPC_REP) begin
         status_in = status_ff & ~req_chan.first_byte;
      end
   end

   always_comb begin
      push_entry.instr_address = req_chan.instr_address;
      push_entry.mode          = mode;
      push_entry.length        = ilp_pkg::instr_length(mode, status_ff);
      push_entry.first_byte    = req_chan.first_byte;
      push_entry.second_byte   = req_chan.second_byte;
      push_entry.third_byte    = req_chan.third_byte;
      push_entry.status_after  = status_in;
   end

   assign start_status_in = csr_pwdata[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         start_status_ff <= ilp_pkg::START_STATUS_RESET;
         status_ff       <= ilp_pkg::START_STATUS_RESET;
      end else if (csr_write) begin
         start_status_ff <= start_status_in;
         status_ff       <= start_status_in;
      end else if (push) begin
         status_ff <= status_in;
      end
   end

endmodule

// File: src/ilp_queue.sv
// Small queue of classified requests between the front end and the back end.
module ilp_queue #(
   parameter int unsigned DEPTH = ilp_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ilp_pkg::decoded_type      push_entry,
   input  logic                      pop,
   output ilp_pkg::decoded_type      pop_entry,
   output ilp_pkg::queue_status_type queue_status
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   ilp_pkg::decoded_type entries [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_in;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;

   assign queue_status.not_empty = count_ff != '0;
   assign queue_status.full      = count_ff == CNT_W'(DEPTH);
   assign pop_entry = entries[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: src/ilp_back.sv
// Back end: assembles the operand, computes branch targets and holds the response.
module ilp_back (
   input  logic                      clock,
   input  logic                      reset,
   input  ilp_pkg::queue_status_type queue_status,
   input  ilp_pkg::decoded_type      pop_entry,
   output logic                      pop,
   ilp_rsp_if.source                 rsp_chan
);

   logic        valid_ff;
   logic [2:0]  length_ff;
   logic [4:0]  addr_mode_ff;
   logic [23:0] operand_ff;
   logic [23:0] operand_in;
   logic [23:0] target_ff;
   logic [23:0] target_in;
   logic [7:0]  status_ff;
   logic [15:0] offset;
   logic [15:0] short_sum;
   logic [15:0] long_sum;

   assign pop = queue_status.not_empty && (!valid_ff || rsp_chan.ready);

   assign offset    = pop_entry.instr_address[15:0];
   assign short_sum = offset + 16'd2 + {{8{pop_entry.first_byte[7]}}, pop_entry.first_byte};
   assign long_sum  = offset + 16'd3 + {pop_entry.second_byte, pop_entry.first_byte};

   always_comb begin
      if (pop_entry.mode == ilp_pkg::AM_AC || pop_entry.mode == ilp_pkg::AM_NO) begin
         operand_in = '0;
      end else if (pop_entry.length == 3'd2) begin
         operand_in = {16'd0, pop_entry.first_byte};
      end else if (pop_entry.length == 3'd3) begin
         operand_in = {8'd0, pop_entry.second_byte, pop_entry.first_byte};
      end else begin
         operand_in = {pop_entry.third_byte, pop_entry.second_byte, pop_entry.first_byte};
      end
   end

   always_comb begin
      if (pop_entry.mode == ilp_pkg::AM_BR) begin
         target_in = {pop_entry.instr_address[23:16], short_sum};
      end else if (pop_entry.mode == ilp_pkg::AM_BL) begin
         target_in = {pop_entry.instr_address[23:16], long_sum};
      end else begin
         target_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         length_ff    <= pop_entry.length;
         addr_mode_ff <= 5'(pop_entry.mode);
         operand_ff   <= operand_in;
         target_ff    <= target_in;
         status_ff    <= pop_entry.status_after;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.length        = length_ff;
   assign rsp_chan.addr_mode     = addr_mode_ff;
   assign rsp_chan.operand_value = operand_ff;
   assign rsp_chan.branch_target = target_ff;
   assign rsp_chan.status_after  = status_ff;

endmodule

// File: src/instruction_length_predecoder_core.sv
// Top level of the instruction length predecoder.
//
// Each request carries one instruction: its 24-bit address, the opcode byte and the
// three bytes that follow. Each request yields exactly one response with the length,
// the addressing mode, the little-endian operand, the branch target for relative
// branches and the tracked status byte after any SEP or REP.
// The front end classifies the opcode and updates the status byte in the cycle a
// request is accepted, so a following request sees the new width flags at once.
// A two-entry queue separates it from the back end, which builds the operand and
// the branch target into a response register.
// Each request passes through a queue entry and then the response register; one request
// is accepted every cycle while the queue is not full.
// When the receiver stalls, the response register holds and the queue fills; the
// request side stalls only once the queue is full.
// Reset empties the queue and loads the status byte and the start status register
// with 0x30. Writing the start status register also reloads the tracked status.
module instruction_length_predecoder_core #(
   parameter int unsigned QUEUE_DEPTH = ilp_pkg::QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   ilp_req_if.sink                        req_chan,
   ilp_rsp_if.source                      rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ilp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ilp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ilp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   ilp_pkg::queue_status_type queue_status;
   ilp_pkg::decoded_type      push_entry;
   ilp_pkg::decoded_type      pop_entry;
   logic                      push;
   logic                      pop;

   assign csr_pready = 1'b1;

   ilp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .queue_status (queue_status),
      .push         (push),
      .push_entry   (push_entry)
   );

   ilp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_entry   (push_entry),
      .pop          (pop),
      .pop_entry    (pop_entry),
      .queue_status (queue_status)
   );

   ilp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .pop_entry    (pop_entry),
      .pop          (pop),
      .rsp_chan     (rsp_chan)
   );

endmodule
